// ===== src/mstw_pkg.sv =====
// Shared constants and controller/datapath handshake types for the spanning tree block.
package mstw_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_FIELD_W   = 6;
  localparam int WEIGHT_FIELD_W = 16;
  localparam int COUNT_FIELD_W  = 7;
  localparam int TOTAL_W        = 22;

  localparam longint TOTAL_MAX = (64'sd1 <<< (TOTAL_W - 1)) - 64'sd1;
  localparam longint TOTAL_MIN = -TOTAL_MAX - 64'sd1;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic add_rd_a;
    logic add_wr_a;
    logic add_rd_b;
    logic add_wr_b;
    logic init_step;
    logic first;
    logic pass_start;
    logic relax_step;
    logic take;
    logic sum_add;
    logic emit;
  } mstw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_ok;
    logic one_way;
    logic count_zero;
    logic j_last;
    logic found;
  } mstw_sts_t;

endpackage

// ===== src/min_spanning_tree_weight.sv =====
// Top level of the dense Prim spanning tree weight block.
//
//   channel   | ports                                                 | handshake
//   ----------+-------------------------------------------------------+------------------------
//   item in   | cmd from_node to_node edge_weight one_way node_count  | start high, busy low
//   result    | total_weight                                          | done, one cycle, no stall
//
// After reset the weight matrix is cleared one entry a cycle, all MAX_NODES*MAX_NODES
// entries, with busy high. An add-edge item is a read-modify-write on the matrix RAM:
// A_RD, A_WR, then B_RD, B_WR for the reverse entry if undirected; it ends after A_RD
// if a node is out of range. A run item with count n > 0 initialises n links, then
// makes one pass over the matrix row of each node that joins. done rises the cycle after
// the S_PICK that finds no node left; a new item may be accepted in that same cycle.
module min_spanning_tree_weight
  import mstw_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [NODE_FIELD_W-1:0]          from_node,
  input  logic [NODE_FIELD_W-1:0]          to_node,
  input  logic signed [WEIGHT_FIELD_W-1:0] edge_weight,
  input  logic                             one_way,
  input  logic [COUNT_FIELD_W-1:0]         node_count,
  output logic                             done,
  output logic signed [TOTAL_W-1:0]        total_weight
);

  mstw_cmd_t ctl;
  mstw_sts_t sts;

  mstw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  mstw_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .from_node    (from_node),
    .to_node      (to_node),
    .edge_weight  (edge_weight),
    .one_way      (one_way),
    .node_count   (node_count),
    .done         (done),
    .total_weight (total_weight)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_ADD)) |=> !done)
    else $error("result raised after add-edge item");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");
`endif

endmodule

// ===== src/mstw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module mstw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mstw_ctrl.sv =====
// Sequencing state machine for edge loading, reset clearing and Prim passes.
module mstw_ctrl
  import mstw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      cmd,
  input  mstw_sts_t sts,
  output mstw_cmd_t ctl,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_WR,
    S_B_RD,
    S_B_WR,
    S_CHECK,
    S_INIT,
    S_PICK,
    S_RELAX,
    S_DRAIN,
    S_TAKE
  } state_t;

  state_t state, state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = (cmd == CMD_RUN) ? S_CHECK : S_A_RD;
        end
      end
      S_A_RD: begin
        ctl.add_rd_a = 1'b1;
        state_next   = sts.range_ok ? S_A_WR : S_IDLE;
      end
      S_A_WR: begin
        ctl.add_wr_a = 1'b1;
        state_next   = sts.one_way ? S_IDLE : S_B_RD;
      end
      S_B_RD: begin
        ctl.add_rd_b = 1'b1;
        state_next   = S_B_WR;
      end
      S_B_WR: begin
        ctl.add_wr_b = 1'b1;
        state_next   = S_IDLE;
      end
      S_CHECK: begin
        if (sts.count_zero) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        ctl.init_step = 1'b1;
        if (sts.j_last) begin
          ctl.first  = 1'b1;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        // a node joins: add its link and relax its row, else no node is left to join
        if (sts.found) begin
          ctl.sum_add    = 1'b1;
          ctl.pass_start = 1'b1;
          state_next     = S_RELAX;
        end else begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RELAX: begin
        ctl.relax_step = 1'b1;
        if (sts.j_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_TAKE;
      end
      S_TAKE: begin
        ctl.take   = 1'b1;
        state_next = S_PICK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== src/mstw_dp.sv =====
// Datapath: weight matrix and link memories, item registers, minimum tracking and sum.
module mstw_dp
  import mstw_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mstw_cmd_t                        ctl,
  output mstw_sts_t                        sts,
  input  logic [NODE_FIELD_W-1:0]          from_node,
  input  logic [NODE_FIELD_W-1:0]          to_node,
  input  logic signed [WEIGHT_FIELD_W-1:0] edge_weight,
  input  logic                             one_way,
  input  logic [COUNT_FIELD_W-1:0]         node_count,
  output logic                             done,
  output logic signed [TOTAL_W-1:0]        total_weight
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = WEIGHT_BITS + 1;
  localparam int LINK_W = WEIGHT_BITS + 2;
  localparam int SUM_W  = WEIGHT_BITS + NODE_W + 1;

  localparam longint W_HI = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
  localparam longint W_LO = -W_HI - 64'sd1;

  logic [NODE_FIELD_W-1:0]       a_r, b_r;
  logic signed [WEIGHT_BITS-1:0] w_r;
  logic                          one_way_r;
  logic [CNT_W-1:0]              count_r;
  logic [ADDR_W-1:0]             clr_cnt;
  logic [CNT_W-1:0]              j;
  logic [NODE_W-1:0]             j_d;
  logic                          rv;
  logic [NODE_W-1:0]             pick;
  logic signed [WEIGHT_BITS-1:0] pick_w;
  logic                          found;
  logic                          nf;
  logic [NODE_W-1:0]             np;
  logic signed [WEIGHT_BITS-1:0] nw;
  logic signed [SUM_W-1:0]       sum;

  longint w_in, w_sat, s_wide, s_sat;

  logic [ADDR_W-1:0] addr_ab, addr_ba, addr_row;
  logic              m_we;
  logic [ADDR_W-1:0] m_waddr, m_raddr;
  logic [ENT_W-1:0]  m_wdata, m_rdata;
  logic              l_we;
  logic [NODE_W-1:0] l_waddr;
  logic [LINK_W-1:0] l_wdata, l_rdata;

  logic                          better;
  logic signed [WEIGHT_BITS-1:0] e_w, l_w, new_w;
  logic                          e_ok, l_ok, l_tree, tree, upd, new_ok, cand;

  always_comb begin
    w_in = longint'(edge_weight);
    if (w_in > W_HI) begin
      w_sat = W_HI;
    end else if (w_in < W_LO) begin
      w_sat = W_LO;
    end else begin
      w_sat = w_in;
    end
    s_wide = longint'(sum);
    if (s_wide > TOTAL_MAX) begin
      s_sat = TOTAL_MAX;
    end else if (s_wide < TOTAL_MIN) begin
      s_sat = TOTAL_MIN;
    end else begin
      s_sat = s_wide;
    end
  end

  assign addr_ab  = ADDR_W'(int'(a_r) * MAX_NODES + int'(b_r));
  assign addr_ba  = ADDR_W'(int'(b_r) * MAX_NODES + int'(a_r));
  assign addr_row = ADDR_W'(int'(pick) * MAX_NODES + int'(j[NODE_W-1:0]));

  // edge store: read-modify-write keeps the lesser of parallel edges
  assign better  = !m_rdata[WEIGHT_BITS] || (w_r < signed'(m_rdata[WEIGHT_BITS-1:0]));
  assign m_raddr = ctl.add_rd_a ? addr_ab : (ctl.add_rd_b ? addr_ba : addr_row);
  assign m_waddr = ctl.clr_step ? clr_cnt : (ctl.add_wr_a ? addr_ab : addr_ba);
  assign m_wdata = ctl.clr_step ? '0 : {1'b1, w_r};
  assign m_we    = ctl.clr_step | ((ctl.add_wr_a | ctl.add_wr_b) & better & sts.range_ok);

  mstw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // relax stage: row entry and link of node j_d arrive together
  assign e_ok   = m_rdata[WEIGHT_BITS];
  assign e_w    = signed'(m_rdata[WEIGHT_BITS-1:0]);
  assign l_tree = l_rdata[WEIGHT_BITS+1];
  assign l_ok   = l_rdata[WEIGHT_BITS];
  assign l_w    = signed'(l_rdata[WEIGHT_BITS-1:0]);
  assign tree   = l_tree | (j_d == pick);
  assign upd    = e_ok && !tree && (!l_ok || (e_w < l_w));
  assign new_ok = l_ok | upd;
  assign new_w  = upd ? e_w : l_w;
  assign cand   = !tree && new_ok && (!nf || (new_w < nw));

  always_comb begin
    if (ctl.init_step) begin
      l_waddr = j[NODE_W-1:0];
      l_wdata = (j == '0) ? {1'b0, 1'b1, {WEIGHT_BITS{1'b0}}} : '0;
    end else begin
      l_waddr = j_d;
      l_wdata = {tree, new_ok, new_w};
    end
  end
  assign l_we = ctl.init_step | rv;

  mstw_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_NODES)
  ) u_link (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (j[NODE_W-1:0]),
    .rdata (l_rdata)
  );

  assign sts.clr_last   = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign sts.range_ok   = (int'(a_r) < MAX_NODES) && (int'(b_r) < MAX_NODES);
  assign sts.one_way    = one_way_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.j_last     = (j == count_r - CNT_W'(1));
  assign sts.found      = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      rv      <= 1'b0;
      done    <= 1'b0;
      found   <= 1'b0;
      nf      <= 1'b0;
      j       <= '0;
    end else begin
      if (ctl.clr_step) clr_cnt <= clr_cnt + ADDR_W'(1);
      rv   <= ctl.relax_step;
      done <= ctl.emit;
      if (ctl.load || ctl.pass_start) begin
        j <= '0;
      end else if (ctl.init_step || ctl.relax_step) begin
        j <= j + CNT_W'(1);
      end
      if (ctl.pass_start) begin
        nf <= 1'b0;
      end else if (rv && cand) begin
        nf <= 1'b1;
      end
      if (ctl.first) begin
        found <= 1'b1;
      end else if (ctl.take) begin
        found <= nf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r       <= from_node;
      b_r       <= to_node;
      w_r       <= WEIGHT_BITS'(w_sat);
      one_way_r <= one_way;
      if (int'(node_count) > MAX_NODES) begin
        count_r <= CNT_W'(MAX_NODES);
      end else begin
        count_r <= CNT_W'(node_count);
      end
    end
    j_d <= j[NODE_W-1:0];
    if (rv && cand) begin
      np <= j_d;
      nw <= new_w;
    end
    if (ctl.first) begin
      pick   <= '0;
      pick_w <= '0;
    end else if (ctl.take) begin
      pick   <= np;
      pick_w <= nw;
    end
    if (ctl.load) begin
      sum <= '0;
    end else if (ctl.sum_add) begin
      sum <= sum + SUM_W'(pick_w);
    end
    if (ctl.emit) total_weight <= TOTAL_W'(s_sat);
  end

`ifndef ASSERT_OFF
  // the link written back in the relax stage is never the one being read
  a_link_no_clash: assert property (@(posedge clk) disable iff (rst)
    (rv && ctl.relax_step) |-> (j_d != j[NODE_W-1:0]))
    else $error("link write and read collide");
`endif

endmodule
